>>> design/rsmp_pkg.sv
// Shared types, constants and filter coefficients for the 48k-to-32k
// stereo resampler. No dependencies.
package rsmp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int FRAC_W       = 15;
  localparam int ACC_W        = 40;
  localparam int INTERP_TAP_N = 28;
  localparam int DECIM_TAP_N  = 29;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_req_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_req_t;

  // Delay-line control: shift moves every cell one place toward the tap,
  // load puts din into the far end instead of wrapping the tap around.
  typedef struct packed {
    logic shift;
    logic load;
  } line_ctl_t;

  // MAC control: clr empties the accumulator, en feeds one product.
  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IMAC,
    ST_IDRAIN,
    ST_PUSH0,
    ST_PUSH1,
    ST_DMAC,
    ST_DDRAIN,
    ST_DOUT
  } state_t;

  // Decimator keeps the interpolated sample seen at this phase.
  localparam logic [1:0] PHASE_OUT = 2'd2;

  localparam sample_t INTERP_COEF [INTERP_TAP_N] = '{
    16'hffcd, 16'h0044, 16'hff96, 16'h00aa, 16'hfef9, 16'h0181,
    16'hfded, 16'h02b9, 16'hfc96, 16'h041a, 16'hfb40, 16'h054f,
    16'hfa43, 16'h0602, 16'h7a15, 16'h0602, 16'hfa43, 16'h054f,
    16'hfb40, 16'h041a, 16'hfc96, 16'h02b9, 16'hfded, 16'h0181,
    16'hfef9, 16'h00aa, 16'hff96, 16'h0044
  };

  localparam sample_t DECIM_COEF [DECIM_TAP_N] = '{
    16'hffea, 16'h0028, 16'hffb3, 16'h008e, 16'hff0c, 16'h0183,
    16'hfdc6, 16'h0315, 16'hfbf8, 16'h0503, 16'hfa0b, 16'h06ca,
    16'hf88f, 16'h07dc, 16'h780f, 16'h07dc, 16'hf88f, 16'h06ca,
    16'hfa0b, 16'h0503, 16'hfbf8, 16'h0315, 16'hfdc6, 16'h0183,
    16'hff0c, 16'h008e, 16'hffb3, 16'h0028, 16'hffea
  };

endpackage

>>> design/rsmp_cell.sv
// One delay-line cell: a single sample register, cleared on reset.
// Depends on rsmp_pkg.
module rsmp_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  rsmp_pkg::sample_t d,
  output rsmp_pkg::sample_t q
);
  import rsmp_pkg::*;

  sample_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

>>> design/rsmp_line.sv
// Ring of rsmp_cell instances forming one delay line; cell 0 holds the
// oldest sample and is the tap. Depends on rsmp_pkg and rsmp_cell.
module rsmp_line #(
  parameter int DEPTH = rsmp_pkg::DECIM_TAP_N
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rsmp_pkg::line_ctl_t ctl,
  input  rsmp_pkg::sample_t   din,
  output rsmp_pkg::sample_t   tap
);
  import rsmp_pkg::*;

  sample_t q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sample_t d;
    if (i == DEPTH - 1) begin : g_end
      // Far end: new sample on a load, otherwise wrap the tap around.
      assign d = ctl.load ? din : q[0];
    end else begin : g_mid
      assign d = q[i+1];
    end
    rsmp_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (ctl.shift),
      .d    (d),
      .q    (q[i])
    );
  end

  assign tap = q[0];

endmodule

>>> design/rsmp_mac.sv
// Serial multiply-accumulate with a registered product, then arithmetic
// shift by FRAC_W and saturation to 16 bits. Depends on rsmp_pkg.
module rsmp_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  rsmp_pkg::mac_ctl_t ctl,
  input  rsmp_pkg::sample_t  sample,
  input  rsmp_pkg::sample_t  coef,
  output rsmp_pkg::sample_t  result
);
  import rsmp_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_W;
  localparam int HI_W   = ACC_W - FRAC_W;
  localparam logic signed [HI_W-1:0] MAX_V = HI_W'(32767);
  localparam logic signed [HI_W-1:0] MIN_V = -(HI_W'(32768));

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [HI_W-1:0]   hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (ctl.clr) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sample * coef;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Dropping the low bits is the floor shift.
  assign hi = $signed(acc_r[ACC_W-1:FRAC_W]);

  always_comb begin
    if (hi > MAX_V) begin
      result = 16'sh7fff;
    end else if (hi < MIN_V) begin
      result = 16'sh8000;
    end else begin
      result = hi[SAMPLE_W-1:0];
    end
  end

endmodule

>>> design/stereo_resampler_48k_to_32k.sv
// Top level of the stereo 48 kHz to 32 kHz resampler: delay lines of rsmp_line,
// six rsmp_mac units and the sequencer. Depends on rsmp_pkg, rsmp_line, rsmp_mac.
//
//   channel   ports                          payload
//   input     in_valid / in_stall / in_data  in_req_t  (left_in, right_in)
//   output    out_valid / out_stall / out_data out_req_t (left_out, right_out)
//
// One frame at a time. The sequencer holds in_stall high from acceptance
// until it is back in idle; a frame that makes an output also runs the
// decimator and waits while the output register stays full. The serial
// MACs set the length of a frame: 14 steps of the interpolator, 29 steps
// of the decimator, one drain each.
// Reset (rst_n low, synchronous) zeroes all delay lines and the decimator
// phase. A result waits in the output register while out_stall is high;
// the sequencer only stalls when it needs that register again.
module stereo_resampler_48k_to_32k #(
  parameter int INTERP_TAP_COUNT = rsmp_pkg::INTERP_TAP_N,
  parameter int DECIM_TAP_COUNT  = rsmp_pkg::DECIM_TAP_N
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsmp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rsmp_pkg::out_req_t out_data
);
  import rsmp_pkg::*;

  localparam int INTERP_PHASES = INTERP_TAP_COUNT / 2;
  localparam int IC_W  = $clog2(INTERP_TAP_COUNT);
  localparam int DC_W  = $clog2(DECIM_TAP_COUNT);
  localparam int CNT_W = (IC_W - 1 > DC_W) ? IC_W - 1 : DC_W;
  localparam logic [CNT_W-1:0] ILAST = CNT_W'(INTERP_PHASES - 1);
  localparam logic [CNT_W-1:0] DLAST = CNT_W'(DECIM_TAP_COUNT - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic             second_r, second_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_req_t         out_data_r, out_data_nxt;

  line_ctl_t ictl, dctl;
  mac_ctl_t  imac_ctl, dmac_ctl;
  logic      accept, slot_free, phase_hit;

  sample_t itap_l, itap_r, dtap_l, dtap_r;
  sample_t ddin_l, ddin_r;
  sample_t odd_l, even_l, odd_r, even_r, dsum_l, dsum_r;
  sample_t coef_odd, coef_even, coef_dec;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign phase_hit = phase_r >= PHASE_OUT;

  // Coefficients follow the rotation: at step t the tap holds line[t].
  assign coef_odd  = INTERP_COEF[{cnt_r[IC_W-2:0], 1'b1}];
  assign coef_even = INTERP_COEF[{cnt_r[IC_W-2:0], 1'b0}];
  assign coef_dec  = DECIM_COEF[cnt_r[DC_W-1:0]];

  // First interpolated sample (odd taps) goes in on the first push,
  // the second (even taps) on the next.
  assign ddin_l = (state_r == ST_PUSH1) ? even_l : odd_l;
  assign ddin_r = (state_r == ST_PUSH1) ? even_r : odd_r;

  // Interpolator delay lines: 14 samples per channel
  rsmp_line #(.DEPTH(INTERP_PHASES)) u_iline_l (
    .clk(clk), .rst_n(rst_n), .ctl(ictl), .din(in_data.left_in), .tap(itap_l)
  );
  rsmp_line #(.DEPTH(INTERP_PHASES)) u_iline_r (
    .clk(clk), .rst_n(rst_n), .ctl(ictl), .din(in_data.right_in), .tap(itap_r)
  );

  // Decimator delay lines: 29 interpolated samples per channel
  rsmp_line #(.DEPTH(DECIM_TAP_COUNT)) u_dline_l (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .din(ddin_l), .tap(dtap_l)
  );
  rsmp_line #(.DEPTH(DECIM_TAP_COUNT)) u_dline_r (
    .clk(clk), .rst_n(rst_n), .ctl(dctl), .din(ddin_r), .tap(dtap_r)
  );

  // Interpolator MACs, both phases in parallel
  rsmp_mac u_mac_odd_l (
    .clk(clk), .rst_n(rst_n), .ctl(imac_ctl), .sample(itap_l), .coef(coef_odd),
    .result(odd_l)
  );
  rsmp_mac u_mac_even_l (
    .clk(clk), .rst_n(rst_n), .ctl(imac_ctl), .sample(itap_l), .coef(coef_even),
    .result(even_l)
  );
  rsmp_mac u_mac_odd_r (
    .clk(clk), .rst_n(rst_n), .ctl(imac_ctl), .sample(itap_r), .coef(coef_odd),
    .result(odd_r)
  );
  rsmp_mac u_mac_even_r (
    .clk(clk), .rst_n(rst_n), .ctl(imac_ctl), .sample(itap_r), .coef(coef_even),
    .result(even_r)
  );

  // Decimator MACs
  rsmp_mac u_mac_dec_l (
    .clk(clk), .rst_n(rst_n), .ctl(dmac_ctl), .sample(dtap_l), .coef(coef_dec),
    .result(dsum_l)
  );
  rsmp_mac u_mac_dec_r (
    .clk(clk), .rst_n(rst_n), .ctl(dmac_ctl), .sample(dtap_r), .coef(coef_dec),
    .result(dsum_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    in_stall      = 1'b1;
    ictl          = '0;
    dctl          = '0;
    imac_ctl      = '0;
    dmac_ctl      = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // Push the new frame into the interpolator lines.
          ictl      = '{shift: 1'b1, load: 1'b1};
          imac_ctl  = '{clr: 1'b1, en: 1'b0};
          cnt_nxt   = '0;
          state_nxt = ST_IMAC;
        end
      end
      ST_IMAC: begin
        ictl     = '{shift: 1'b1, load: 1'b0};
        imac_ctl = '{clr: 1'b0, en: 1'b1};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == ILAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDRAIN;
        end
      end
      ST_IDRAIN: begin
        state_nxt = ST_PUSH0;
      end
      ST_PUSH0, ST_PUSH1: begin
        dctl       = '{shift: 1'b1, load: 1'b1};
        dmac_ctl   = '{clr: 1'b1, en: 1'b0};
        second_nxt = (state_r == ST_PUSH1);
        cnt_nxt    = '0;
        if (phase_hit) begin
          phase_nxt = '0;
          state_nxt = ST_DMAC;
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = (state_r == ST_PUSH1) ? ST_IDLE : ST_PUSH1;
        end
      end
      ST_DMAC: begin
        dctl     = '{shift: 1'b1, load: 1'b0};
        dmac_ctl = '{clr: 1'b0, en: 1'b1};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == DLAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DDRAIN;
        end
      end
      ST_DDRAIN: begin
        state_nxt = ST_DOUT;
      end
      ST_DOUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{left_out: dsum_l, right_out: dsum_r};
          state_nxt     = second_r ? ST_IDLE : ST_PUSH1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PHASE_OUT)
    else $error("decimator phase out of range");

  a_out_from_dout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DOUT))
    else $error("output raised outside result state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_IMAC) && (cnt_r == '0))
    else $error("accepted request did not start interpolation");

  a_dmac_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DMAC) && (cnt_r == '0) |->
      $past(state_r == ST_PUSH0 || state_r == ST_PUSH1) && (phase_r == '0))
    else $error("decimator sum started without a phase hit");
`endif

endmodule
